### hdl/wse_pkg.sv
// Shared types and constants for the WS2812 pixel to SPI symbol encoder.
package wse_pkg;

   // 2-bit channel codes held in the channel order register
   typedef enum logic [1:0] {
      CH_NONE  = 2'd0,
      CH_RED   = 2'd1,
      CH_GREEN = 2'd2,
      CH_BLUE  = 2'd3
   } chan_code_type;

   // register indexes on the csr port
   localparam logic [1:0] REG_CHANNEL_ORDER  = 2'd0;
   localparam logic [1:0] REG_LEDS_PER_PIXEL = 2'd1;

   localparam logic [7:0] CHANNEL_ORDER_RESET  = 8'd54;
   localparam logic [4:0] LEDS_PER_PIXEL_RESET = 5'd1;

   localparam logic [7:0] SYM_ONE  = 8'hF8;
   localparam logic [7:0] SYM_ZERO = 8'hE0;

   typedef struct packed {
      logic [7:0] channel_order;
      logic [4:0] leds_per_pixel;
   } cfg_type;

   // brightness-scaled pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

### hdl/ws2812_pixel_spi_encoder.sv
// Top level: WS2812 pixel to SPI symbol pattern encoder.
//
//  channel | dir | transfer when          | payload
//  req_    | in  | req_tvalid & tready    | one pixel: red, green, blue, brightness
//  rsp_    | out | rsp_tvalid & tready    | one channel byte and its 64-bit SPI pattern
//  csr_    | in  | csr_valid & csr_ready  | register write, index 0 order, 1 repeat
//
// Pipeline: input register, multiply register, sequencer, output register.
// A pixel yields min(repeats, MAX_REPEAT) * (nonzero order codes) results, one per
// cycle unless rsp_tready stalls; the sequencer takes the next pixel as it emits the
// last result of the current one, and a pixel that yields none is dropped on load.
// Synchronous active-high reset clears valid bits and restores registers.
// Stalls on rsp_tready back up through the stages; nothing is lost or repeated.
module ws2812_pixel_spi_encoder
   import wse_pkg::*;
#(
   parameter int MAX_REPEAT = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], brightness[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // spi_pattern[63:0], scaled_value[71:64]
   output logic        rsp_tlast,   // last_of_pixel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   cfg_type     cfg_ff, cfg_in;
   hs_type      pix_hs;
   pixel_type   pix;
   logic        seq_ready;
   logic [63:0] pattern;
   logic [7:0]  value;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CHANNEL_ORDER:  cfg_in.channel_order  = csr_data;
            REG_LEDS_PER_PIXEL: cfg_in.leds_per_pixel = csr_data[4:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_order  <= CHANNEL_ORDER_RESET;
         cfg_ff.leds_per_pixel <= LEDS_PER_PIXEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wse_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_red    (req_tdata[7:0]),
      .in_green  (req_tdata[15:8]),
      .in_blue   (req_tdata[23:16]),
      .in_bright (req_tdata[31:24]),
      .out_ready (seq_ready),
      .out_hs    (pix_hs),
      .out_pix   (pix)
   );

   wse_sequencer #(
      .MAX_REPEAT (MAX_REPEAT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pix_valid   (pix_hs.valid),
      .pix_ready   (seq_ready),
      .pix         (pix),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_pattern (pattern),
      .rsp_value   (value),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {value, pattern};

endmodule

### hdl/wse_scale.sv
// Input register and brightness multiply stages.
module wse_scale
   import wse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_red,
   input  logic [7:0] in_green,
   input  logic [7:0] in_blue,
   input  logic [7:0] in_bright,
   input  logic       out_ready,
   output hs_type     out_hs,
   output pixel_type  out_pix
);

   logic       a_vld_ff, a_vld_in;
   logic [7:0] a_red_ff, a_green_ff, a_blue_ff, a_bright_ff;
   logic       b_vld_ff, b_vld_in;
   pixel_type  b_pix_ff, b_pix_in;
   logic       a_adv, b_adv;
   logic [8:0] scale;
   logic [16:0] prod_r, prod_g, prod_b;

   assign b_adv    = !b_vld_ff || out_ready;
   assign a_adv    = !a_vld_ff || b_adv;
   assign in_ready = a_adv;

   always_comb begin
      a_vld_in = a_adv ? in_valid : a_vld_ff;
      b_vld_in = b_adv ? a_vld_ff : b_vld_ff;
      scale    = {1'b0, a_bright_ff} + 9'd1;
      prod_r   = {9'd0, a_red_ff} * {8'd0, scale};
      prod_g   = {9'd0, a_green_ff} * {8'd0, scale};
      prod_b   = {9'd0, a_blue_ff} * {8'd0, scale};
      // product never exceeds 255 * 256, so bit 16 stays clear
      b_pix_in.red   = prod_r[15:8];
      b_pix_in.green = prod_g[15:8];
      b_pix_in.blue  = prod_b[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_red_ff    <= in_red;
         a_green_ff  <= in_green;
         a_blue_ff   <= in_blue;
         a_bright_ff <= in_bright;
      end
      if (b_adv) begin
         b_pix_ff <= b_pix_in;
      end
   end

   assign out_hs.valid = b_vld_ff;
   assign out_hs.ready = b_adv;
   assign out_pix      = b_pix_ff;

endmodule

### hdl/wse_sequencer.sv
// Repeat and channel order sequencer with symbol expansion and output register.
module wse_sequencer
   import wse_pkg::*;
#(
   parameter int MAX_REPEAT = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        pix_valid,
   output logic        pix_ready,
   input  pixel_type   pix,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_pattern,
   output logic [7:0]  rsp_value,
   output logic        rsp_last
);

   localparam int REP_W = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT + 1) : 1;

   function automatic logic [63:0] expand_byte(input logic [7:0] v);
      logic [63:0] pat;
      pat = '0;
      for (int i = 0; i < 8; i++) begin
         pat[8*i +: 8] = v[i] ? SYM_ONE : SYM_ZERO;
      end
      return pat;
   endfunction

   logic             busy_ff, busy_in;
   chan_code_type    list_ff [4];
   chan_code_type    list_in [4];
   logic [2:0]       cnt_ff, cnt_in;
   logic [1:0]       pos_ff, pos_in;
   logic [REP_W-1:0] rep_ff, rep_in;
   logic [REP_W-1:0] reps_ff, reps_in;
   pixel_type        pix_ff, pix_in;

   logic             out_vld_ff, out_vld_in;
   logic [63:0]      pattern_ff, pattern_in;
   logic [7:0]       value_ff, value_in;
   logic             last_ff, last_in;

   chan_code_type    cl_list [4];
   logic [2:0]       cl_cnt;
   logic [REP_W-1:0] cl_reps;
   logic             out_adv, emit, pos_last, rep_last, load;
   logic [7:0]       sel;

   // compact the nonzero codes of the order register, low pair first, and clamp the repeat count to MAX_REPEAT
   always_comb begin
      cl_cnt = 3'd0;
      for (int i = 0; i < 4; i++) begin
         cl_list[i] = CH_NONE;
      end
      for (int i = 0; i < 4; i++) begin
         if (cfg.channel_order[2*i +: 2] != 2'd0) begin
            cl_list[cl_cnt[1:0]] = chan_code_type'(cfg.channel_order[2*i +: 2]);
            cl_cnt = cl_cnt + 3'd1;
         end
      end
      if (cfg.leds_per_pixel > 5'(MAX_REPEAT)) begin
         cl_reps = REP_W'(MAX_REPEAT);
      end else begin
         cl_reps = REP_W'(cfg.leds_per_pixel);
      end
   end

   assign out_adv   = !out_vld_ff || rsp_ready;
   assign emit      = busy_ff && out_adv;
   assign pos_last  = ({1'b0, pos_ff} + 3'd1) == cnt_ff;
   assign rep_last  = (rep_ff + REP_W'(1)) == reps_ff;
   assign pix_ready = !busy_ff || (emit && pos_last && rep_last);
   assign load      = pix_valid && pix_ready;

   always_comb begin
      case (list_ff[pos_ff])
         CH_RED:   sel = pix_ff.red;
         CH_GREEN: sel = pix_ff.green;
         CH_BLUE:  sel = pix_ff.blue;
         default:  sel = 8'd0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      list_in = list_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      rep_in  = rep_ff;
      reps_in = reps_ff;
      pix_in  = pix_ff;
      if (load) begin
         // a pixel with no codes or no repeats drops out here
         busy_in = (cl_cnt != 3'd0) && (cl_reps != '0);
         list_in = cl_list;
         cnt_in  = cl_cnt;
         pos_in  = 2'd0;
         rep_in  = '0;
         reps_in = cl_reps;
         pix_in  = pix;
      end else if (emit) begin
         if (pos_last && rep_last) begin
            busy_in = 1'b0;
         end else if (pos_last) begin
            pos_in = 2'd0;
            rep_in = rep_ff + REP_W'(1);
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      pattern_in = pattern_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      if (emit) begin
         out_vld_in = 1'b1;
         pattern_in = expand_byte(sel);
         value_in   = sel;
         last_in    = pos_last && rep_last;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff    <= list_in;
      cnt_ff     <= cnt_in;
      pos_ff     <= pos_in;
      rep_ff     <= rep_in;
      reps_ff    <= reps_in;
      pix_ff     <= pix_in;
      pattern_ff <= pattern_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_pattern = pattern_ff;
   assign rsp_value   = value_ff;
   assign rsp_last    = last_ff;

endmodule

### dv/ws2812_spi_checker.sv
// Checker for the WS2812 pixel encoder: predicts SPI symbol bytes and compares results.
`timescale 1ns / 1ps

module ws2812_spi_checker
   import wse_pkg::*;
#(
   parameter int MAX_REPEAT = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], brightness[31:24]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // spi_pattern[63:0], scaled_value[71:64]
   input  logic        rsp_tlast,   // last_of_pixel
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          mismatches,
   output int          due_count,
   output int          pixels_seen,
   output int          bytes_checked
);

   localparam int MAX_RESULTS = 4 * MAX_REPEAT;

   typedef struct packed {
      logic [63:0] pattern;
      logic [7:0]  level;
      logic        last;
   } led_byte_type;

   cfg_type      shadow_cfg;
   led_byte_type led_bytes_due[$];
   int           fail_total;
   int           pixel_total;
   int           byte_total;

   function automatic logic [7:0] scale_level(logic [7:0] level, logic [7:0] bright);
      logic [8:0]  bright_p1;
      logic [16:0] prod;
      bright_p1 = {1'b0, bright} + 9'd1;
      prod = {9'd0, level} * {8'd0, bright_p1};
      return prod[15:8];
   endfunction

   // MSB first, first symbol lands in the top byte
   function automatic logic [63:0] symbol_pattern(logic [7:0] level);
      logic [63:0] pat;
      pat = '0;
      for (int i = 7; i >= 0; i--)
         pat = {pat[55:0], level[i] ? SYM_ONE : SYM_ZERO};
      return pat;
   endfunction

   function automatic void queue_pixel(logic [31:0] pixel);
      logic [7:0]    level [0:3];
      logic [7:0]    seq;
      chan_code_type code;
      int            reps;
      int            per_rep;
      int            total;
      int            n;
      led_byte_type  beat;
      level[CH_NONE]  = 8'd0;
      level[CH_RED]   = scale_level(pixel[7:0], pixel[31:24]);
      level[CH_GREEN] = scale_level(pixel[15:8], pixel[31:24]);
      level[CH_BLUE]  = scale_level(pixel[23:16], pixel[31:24]);
      reps = (int'(shadow_cfg.leds_per_pixel) > MAX_REPEAT) ?
             MAX_REPEAT : int'(shadow_cfg.leds_per_pixel);
      per_rep = 0;
      for (seq = shadow_cfg.channel_order; seq != 8'd0; seq = seq >> 2)
         if (chan_code_type'(seq[1:0]) != CH_NONE) per_rep++;
      total = reps * per_rep;
      if (total > MAX_RESULTS) total = MAX_RESULTS;
      n = 0;
      for (int r = 0; r < reps; r++) begin
         // zero pairs below a nonzero pair are skipped
         for (seq = shadow_cfg.channel_order; seq != 8'd0; seq = seq >> 2) begin
            code = chan_code_type'(seq[1:0]);
            if (code != CH_NONE && n < total) begin
               beat.pattern = symbol_pattern(level[code]);
               beat.level   = level[code];
               beat.last    = (n == total - 1);
               led_bytes_due.push_back(beat);
               n++;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      led_byte_type want;
      if (reset) begin
         shadow_cfg.channel_order  = CHANNEL_ORDER_RESET;
         shadow_cfg.leds_per_pixel = LEDS_PER_PIXEL_RESET;
         led_bytes_due.delete();
         fail_total  = 0;
         pixel_total = 0;
         byte_total  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (led_bytes_due.size() == 0) begin
               $error("unexpected result transfer: spi_pattern %h, scaled_value %h",
                      rsp_tdata[63:0], rsp_tdata[71:64]);
               fail_total++;
            end else begin
               want = led_bytes_due.pop_front();
               byte_total++;
               if (rsp_tdata[63:0] !== want.pattern) begin
                  $error("spi_pattern: expected %h, actual %h", want.pattern,
                         rsp_tdata[63:0]);
                  fail_total++;
               end
               if (rsp_tdata[71:64] !== want.level) begin
                  $error("scaled_value: expected %h, actual %h", want.level,
                         rsp_tdata[71:64]);
                  fail_total++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_pixel: expected %b, actual %b", want.last, rsp_tlast);
                  fail_total++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            // unmapped indexes are ignored
            if (csr_index == REG_CHANNEL_ORDER)
               shadow_cfg.channel_order = csr_data;
            else if (csr_index == REG_LEDS_PER_PIXEL)
               shadow_cfg.leds_per_pixel = csr_data[4:0];
         end
         if (req_tvalid && req_tready) begin
            queue_pixel(req_tdata);
            pixel_total++;
         end
      end
      mismatches    <= fail_total;
      due_count     <= led_bytes_due.size();
      pixels_seen   <= pixel_total;
      bytes_checked <= byte_total;
   end

endmodule

### dv/tb_top.sv
// Testbench top: drives pixels, register writes and output stalls, and reports the verdict.
`timescale 1ns / 1ps

module tb_top
   import wse_pkg::*;
();

   localparam int MAX_REPEAT      = 16;
   localparam int RANDOM_PIXELS   = 380;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;

   // indexes with no register behind them
   localparam logic [1:0] REG_UNMAPPED_2 = 2'd2;
   localparam logic [1:0] REG_UNMAPPED_3 = 2'd3;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // red[7:0], green[15:8], blue[23:16], brightness[31:24]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // spi_pattern[63:0], scaled_value[71:64]
   logic        rsp_tlast;   // last_of_pixel
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   logic        hold_off_req;
   bit          req_steady;
   int          settings_used;
   int          quiet_cycles;
   int          mismatches;
   int          due_count;
   int          pixels_seen;
   int          bytes_checked;

   always #5ns clock = ~clock;

   ws2812_pixel_spi_encoder #(
      .MAX_REPEAT (MAX_REPEAT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ws2812_spi_checker #(
      .MAX_REPEAT (MAX_REPEAT)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .due_count     (due_count),
      .pixels_seen   (pixels_seen),
      .bytes_checked (bytes_checked)
   );

   // valid stays high across back-to-back transfers; it drops only for a gap
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] bright);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {bright, b, g, r};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] order, input logic [7:0] reps_raw);
      write_reg(REG_CHANNEL_ORDER, order);
      write_reg(REG_LEDS_PER_PIXEL, reps_raw);
      settings_used++;
      req_steady = ($urandom_range(0, 2) == 0);
   endtask

   // due_count is registered behind the checker's queue, hence the first wait
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : rsp_sink
      int gap;
      int taken;
      bit steady;
      bit held;
      taken  = 0;
      steady = 0;
      held   = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0) steady = ($urandom_range(0, 2) == 0);
         gap = steady ? 0 : $urandom_range(0, 9);
         // one long stall so the block backs up into its input
         if (hold_off_req && !held) begin
            gap  = HOLD_OFF_CYCLES;
            held = 1;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int         remaining;
      int         phase_len;
      bit         big;
      bit         first;
      logic [4:0] reps;
      logic [2:0] junk;
      logic [7:0] order;
      logic [7:0] bright;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= REG_CHANNEL_ORDER;
      csr_data     <= '0;
      hold_off_req <= 1'b0;
      settings_used = 1;
      req_steady = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: green, red, blue, one LED
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'h80, 8'h7F);
      send_pixel(8'hAA, 8'h55, 8'h01, 8'hFF);
      send_pixel(8'h55, 8'hAA, 8'hFE, 8'hFF);
      send_pixel(8'h01, 8'h80, 8'hFF, 8'hFE);
      wait_drained();

      // red, skipped pair, blue; upper bits of the repeat write are dropped
      configure(8'h31, 8'hE3);
      send_pixel(8'hC3, 8'h3C, 8'h96, 8'hFF);
      send_pixel(8'h7E, 8'h81, 8'h18, 8'h9A);
      wait_drained();

      // empty order, plus writes to unmapped indexes
      configure(8'h00, 8'h02);
      write_reg(REG_UNMAPPED_2, 8'h5A);
      write_reg(REG_UNMAPPED_3, 8'hA5);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
      wait_drained();

      // repeat far above the limit: sixty-four blue bytes
      configure(8'hFF, 8'h1F);
      send_pixel(8'h0F, 8'hF0, 8'hA5, 8'hFF);
      wait_drained();

      // repeat just above the limit, blue, green, red
      configure(8'h1B, 8'h11);
      send_pixel(8'hFF, 8'h80, 8'h01, 8'hC0);
      wait_drained();

      // zero repeat gives nothing
      configure(8'hE4, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h80, 8'h40, 8'h20, 8'h10);
      wait_drained();

      // three skipped pairs below red, full repeat
      configure(8'h40, 8'h10);
      send_pixel(8'hB7, 8'h00, 8'h00, 8'hFF);
      wait_drained();

      configure(8'h80, 8'h01);
      send_pixel(8'h00, 8'hFF, 8'h00, 8'h80);
      send_pixel(8'h00, 8'h01, 8'h00, 8'hFF);
      wait_drained();

      remaining = RANDOM_PIXELS;
      first = 1;
      while (remaining > 0) begin
         order = 8'($urandom_range(1, 255));
         big   = !first && ($urandom_range(0, 9) == 0);
         reps  = big ? 5'($urandom_range(5, 31)) : 5'($urandom_range(1, 4));
         junk  = 3'($urandom_range(0, 7));
         configure(order, {junk, reps});
         phase_len = big ? $urandom_range(3, 8) : $urandom_range(25, 60);
         if (phase_len > remaining) phase_len = remaining;
         if (first) begin
            hold_off_req <= 1'b1;
            req_steady = 1;
         end
         first = 0;
         repeat (phase_len) begin
            case ($urandom_range(0, 7))
               0:       bright = 8'hFF;
               1:       bright = 8'h00;
               default: bright = 8'($urandom_range(0, 255));
            endcase
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), bright);
         end
         remaining -= phase_len;
         wait_drained();
      end

      $display("Covered %0d pixels over %0d register settings, %0d channel bytes compared.",
               pixels_seen, settings_used, bytes_checked);
      $display("Included empty order, zero and oversized repeats, and a long output stall.");
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hdl/wse_pkg.sv
hdl/wse_scale.sv
hdl/wse_sequencer.sv
hdl/ws2812_pixel_spi_encoder.sv
dv/ws2812_spi_checker.sv
dv/tb_top.sv
